// ===== rtl/qslp_pkg.sv =====
// shared types and constants for the quaternion slerp pipeline
// no dependencies; every other file imports this package
package qslp_pkg;

  localparam int CordicSteps = 30;
  localparam int RootSteps   = 29;
  localparam int QuoBits     = 32;

  // dot below 0.01 in Q.28 is skipped
  localparam logic [32:0] SkipLimit  = 33'd2684355;
  // sine of theta above 0.00001 in Q.28
  localparam logic [28:0] RootLimit  = 29'd2685;
  localparam logic signed [33:0] CordicGain = 34'sh26DD3B6A;

  localparam logic [31:0] AtanQ30 [CordicSteps] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic signed [15:0] before_w;
    logic signed [15:0] before_x;
    logic signed [15:0] before_y;
    logic signed [15:0] before_z;
    logic signed [15:0] after_w;
    logic signed [15:0] after_x;
    logic signed [15:0] after_y;
    logic signed [15:0] after_z;
    logic [15:0]        blend;
  } operand_t;

  typedef struct packed {
    logic signed [15:0] out_w;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               skipped;
  } result_t;

  // per-beat data that rides along the pipeline
  typedef struct packed {
    logic [3:0][15:0] b;
    logic [3:0][16:0] a;
    logic [15:0]      t;
    logic             skip;
    logic             big;
    logic             fall;
    logic [28:0]      root;
  } side_t;

endpackage

// ===== rtl/quaternion_slerp.sv =====
// Spherical interpolation of two Q1.14 quaternions by a Q1.15 fraction, fully
// pipelined: one operand beat is taken every cycle while the pipeline advances,
// through 5 front stages, 29 square-root stages, 32 for the angle CORDIC
// and its split by t, 30 for the sine CORDIC, 32 for the divider and 3 for the
// final mix. The whole pipeline holds while a finished result is stalled.
// depends on qslp_pkg and the qslp_* stage modules
module quaternion_slerp import qslp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     operand_valid,
  output logic     operand_stall,
  input  operand_t operand,
  output logic     result_valid,
  input  logic     result_stall,
  output result_t  result
);

  logic en;
  logic f_valid, r_valid, v_valid, s_valid, d_valid;
  side_t f_side, r_side, v_side, s_side, d_side;
  logic [27:0] f_dot, r_dot;
  logic [56:0] f_rad;
  logic [1:0][30:0] v_ang;
  logic [1:0][32:0] s_sine;
  logic [1:0][31:0] d_quo;

  // pipeline advances unless the output beat is held
  assign en = !(result_valid && result_stall);
  assign operand_stall = !en;

  qslp_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(operand_valid), .beat(operand),
    .out_valid(f_valid), .side(f_side), .dot(f_dot), .rad(f_rad)
  );

  qslp_isqrt u_isqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(f_valid), .side_in(f_side),
    .dot_in(f_dot), .rad(f_rad), .out_valid(r_valid), .side(r_side), .dot(r_dot)
  );

  qslp_vec u_vec (
    .clk(clk), .rst(rst), .en(en), .in_valid(r_valid), .side_in(r_side),
    .dot(r_dot), .out_valid(v_valid), .side(v_side), .ang(v_ang)
  );

  qslp_sin u_sin (
    .clk(clk), .rst(rst), .en(en), .in_valid(v_valid), .side_in(v_side),
    .ang(v_ang), .out_valid(s_valid), .side(s_side), .sine(s_sine)
  );

  qslp_div u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_valid), .side_in(s_side),
    .sine(s_sine), .out_valid(d_valid), .side(d_side), .quo(d_quo)
  );

  qslp_mix u_mix (
    .clk(clk), .rst(rst), .en(en), .in_valid(d_valid), .side(d_side),
    .quo(d_quo), .out_valid(result_valid), .result(result)
  );

endmodule

// ===== rtl/qslp_front.sv =====
// front end: dot product, sign fix, skip test and 1 - dot^2
// depends on qslp_pkg
module qslp_front import qslp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  operand_t     beat,
  output logic         out_valid,
  output side_t        side,
  output logic [27:0]  dot,
  output logic [56:0]  rad
);

  logic [4:0] vld;
  logic [3:0][15:0] bq, aq;
  logic [15:0] tq;

  logic signed [31:0] prod [4];
  logic [3:0][15:0] b1, a1, b2, a2;
  logic [15:0] t1, t2;
  logic signed [33:0] dot2;
  side_t side3, side4, side5;
  logic [27:0] dot3, dot4, dot5;
  logic [55:0] sq4;
  logic [56:0] rad5;

  logic [33:0] mag;
  logic [32:0] dabs;
  logic neg;
  side_t side3_next;

  assign bq = {beat.before_z, beat.before_y, beat.before_x, beat.before_w};
  assign aq = {beat.after_z, beat.after_y, beat.after_x, beat.after_w};
  assign tq = (beat.blend > 16'd32768) ? 16'd32768 : beat.blend;

  // sign fix and skip test
  always_comb begin
    neg  = dot2[33];
    mag  = neg ? -dot2 : dot2;
    dabs = mag[32:0];
    side3_next = '0;
    side3_next.b = b2;
    for (int i = 0; i < 4; i++) begin
      side3_next.a[i] = neg ? -{a2[i][15], a2[i]} : {a2[i][15], a2[i]};
    end
    side3_next.t    = t2;
    side3_next.skip = dabs < SkipLimit;
    side3_next.big  = |dabs[32:28];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        prod[i] <= $signed(bq[i]) * $signed(aq[i]);
      end
      b1 <= bq;
      a1 <= aq;
      t1 <= tq;
      dot2 <= 34'(prod[0]) + 34'(prod[1]) + 34'(prod[2]) + 34'(prod[3]);
      b2 <= b1;
      a2 <= a1;
      t2 <= t1;
      side3 <= side3_next;
      dot3 <= dabs[27:0];
      side4 <= side3;
      dot4 <= dot3;
      sq4 <= dot3 * dot3;
      side5 <= side4;
      dot5 <= dot4;
      rad5 <= {1'b1, 56'd0} - {1'b0, sq4};
    end
  end

  assign out_valid = vld[4];
  assign side = side5;
  assign dot = dot5;
  assign rad = rad5;

endmodule

// ===== rtl/qslp_isqrt.sv =====
// pipelined integer square root, one result bit per stage
// depends on qslp_pkg
module qslp_isqrt import qslp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  side_t        side_in,
  input  logic [27:0]  dot_in,
  input  logic [56:0]  rad,
  output logic         out_valid,
  output side_t        side,
  output logic [27:0]  dot
);

  logic [RootSteps-1:0] vld;
  logic [57:0] rem [RootSteps];
  logic [57:0] root [RootSteps];
  logic [27:0] dot_s [RootSteps];
  side_t side_s [RootSteps];

  logic [57:0] rem_in [RootSteps];
  logic [57:0] root_in [RootSteps];
  logic [57:0] trial [RootSteps];
  logic [57:0] rem_next [RootSteps];
  logic [57:0] root_next [RootSteps];

  // one restoring root step per stage
  always_comb begin
    rem_in[0]  = {1'b0, rad};
    root_in[0] = '0;
    for (int i = 1; i < RootSteps; i++) begin
      rem_in[i]  = rem[i-1];
      root_in[i] = root[i-1];
    end
    for (int i = 0; i < RootSteps; i++) begin
      trial[i] = root_in[i] + (58'd1 << (2 * (RootSteps - 1 - i)));
      if (rem_in[i] >= trial[i]) begin
        rem_next[i]  = rem_in[i] - trial[i];
        root_next[i] = (root_in[i] >> 1) + (58'd1 << (2 * (RootSteps - 1 - i)));
      end else begin
        rem_next[i]  = rem_in[i];
        root_next[i] = root_in[i] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[RootSteps-2:0], in_valid};
    end
    if (en) begin
      for (int i = 0; i < RootSteps; i++) begin
        rem[i]  <= rem_next[i];
        root[i] <= root_next[i];
      end
      side_s[0] <= side_in;
      dot_s[0]  <= dot_in;
      for (int i = 1; i < RootSteps; i++) begin
        side_s[i] <= side_s[i-1];
        dot_s[i]  <= dot_s[i-1];
      end
    end
  end

  // attach the root and the small-angle flag
  always_comb begin
    side      = side_s[RootSteps-1];
    side.root = root[RootSteps-1][28:0];
    side.fall = side_s[RootSteps-1].big || (root[RootSteps-1][28:0] < RootLimit);
  end

  assign out_valid = vld[RootSteps-1];
  assign dot = dot_s[RootSteps-1];

endmodule

// ===== rtl/qslp_vec.sv =====
// cordic vectoring for theta, then the split of theta by t
// depends on qslp_pkg
module qslp_vec import qslp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  side_t            side_in,
  input  logic [27:0]      dot,
  output logic             out_valid,
  output side_t            side,
  output logic [1:0][30:0] ang
);

  logic [CordicSteps+1:0] vld;
  logic signed [33:0] x [CordicSteps];
  logic signed [33:0] y [CordicSteps];
  logic signed [32:0] z [CordicSteps];
  side_t side_s [CordicSteps];

  logic signed [33:0] x_in [CordicSteps];
  logic signed [33:0] y_in [CordicSteps];
  logic signed [32:0] z_in [CordicSteps];
  logic signed [33:0] x_next [CordicSteps];
  logic signed [33:0] y_next [CordicSteps];
  logic signed [32:0] z_next [CordicSteps];

  logic [30:0] theta_c, theta_a, a1_c;
  logic [46:0] prod_a;
  side_t side_a, side_b;
  logic [1:0][30:0] ang_b;

  // one micro-rotation per stage, driving y toward zero
  always_comb begin
    x_in[0] = {4'd0, dot, 2'd0};
    y_in[0] = {3'd0, side_in.root, 2'd0};
    z_in[0] = '0;
    for (int i = 1; i < CordicSteps; i++) begin
      x_in[i] = x[i-1];
      y_in[i] = y[i-1];
      z_in[i] = z[i-1];
    end
    for (int i = 0; i < CordicSteps; i++) begin
      if (y_in[i] > 0) begin
        x_next[i] = x_in[i] + (y_in[i] >>> i);
        y_next[i] = y_in[i] - (x_in[i] >>> i);
        z_next[i] = z_in[i] + $signed({1'b0, AtanQ30[i]});
      end else begin
        x_next[i] = x_in[i] - (y_in[i] >>> i);
        y_next[i] = y_in[i] + (x_in[i] >>> i);
        z_next[i] = z_in[i] - $signed({1'b0, AtanQ30[i]});
      end
    end
  end

  assign theta_c = z[CordicSteps-1][32] ? '0 : z[CordicSteps-1][30:0];
  assign a1_c = prod_a[45:15];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[CordicSteps:0], in_valid};
    end
    if (en) begin
      for (int i = 0; i < CordicSteps; i++) begin
        x[i] <= x_next[i];
        y[i] <= y_next[i];
        z[i] <= z_next[i];
      end
      side_s[0] <= side_in;
      for (int i = 1; i < CordicSteps; i++) begin
        side_s[i] <= side_s[i-1];
      end
      // t * theta
      theta_a <= theta_c;
      prod_a  <= theta_c * side_s[CordicSteps-1].t;
      side_a  <= side_s[CordicSteps-1];
      // (1-t) * theta and t * theta
      ang_b[0] <= theta_a - a1_c;
      ang_b[1] <= a1_c;
      side_b   <= side_a;
    end
  end

  assign out_valid = vld[CordicSteps+1];
  assign side = side_b;
  assign ang = ang_b;

endmodule

// ===== rtl/qslp_sin.sv =====
// two-lane cordic rotation giving the sine of both partial angles
// depends on qslp_pkg
module qslp_sin import qslp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  side_t            side_in,
  input  logic [1:0][30:0] ang,
  output logic             out_valid,
  output side_t            side,
  output logic [1:0][32:0] sine
);

  logic [CordicSteps-1:0] vld;
  logic signed [33:0] x [CordicSteps][2];
  logic signed [33:0] y [CordicSteps][2];
  logic signed [32:0] z [CordicSteps][2];
  side_t side_s [CordicSteps];

  logic signed [33:0] x_in [CordicSteps][2];
  logic signed [33:0] y_in [CordicSteps][2];
  logic signed [32:0] z_in [CordicSteps][2];
  logic signed [33:0] x_next [CordicSteps][2];
  logic signed [33:0] y_next [CordicSteps][2];
  logic signed [32:0] z_next [CordicSteps][2];

  // one micro-rotation per stage, driving z toward zero
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      x_in[0][l] = CordicGain;
      y_in[0][l] = '0;
      z_in[0][l] = {2'd0, ang[l]};
      for (int i = 1; i < CordicSteps; i++) begin
        x_in[i][l] = x[i-1][l];
        y_in[i][l] = y[i-1][l];
        z_in[i][l] = z[i-1][l];
      end
      for (int i = 0; i < CordicSteps; i++) begin
        if (z_in[i][l] >= 0) begin
          x_next[i][l] = x_in[i][l] - (y_in[i][l] >>> i);
          y_next[i][l] = y_in[i][l] + (x_in[i][l] >>> i);
          z_next[i][l] = z_in[i][l] - $signed({1'b0, AtanQ30[i]});
        end else begin
          x_next[i][l] = x_in[i][l] + (y_in[i][l] >>> i);
          y_next[i][l] = y_in[i][l] - (x_in[i][l] >>> i);
          z_next[i][l] = z_in[i][l] + $signed({1'b0, AtanQ30[i]});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[CordicSteps-2:0], in_valid};
    end
    if (en) begin
      for (int i = 0; i < CordicSteps; i++) begin
        for (int l = 0; l < 2; l++) begin
          x[i][l] <= x_next[i][l];
          y[i][l] <= y_next[i][l];
          z[i][l] <= z_next[i][l];
        end
      end
      side_s[0] <= side_in;
      for (int i = 1; i < CordicSteps; i++) begin
        side_s[i] <= side_s[i-1];
      end
    end
  end

  // negative sines clamp to zero
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sine[l] = y[CordicSteps-1][l][33] ? '0 : y[CordicSteps-1][l][32:0];
    end
  end

  assign out_valid = vld[CordicSteps-1];
  assign side = side_s[CordicSteps-1];

endmodule

// ===== rtl/qslp_div.sv =====
// two-lane pipelined restoring divider: sine * 2^30 / (4 * root)
// depends on qslp_pkg
module qslp_div import qslp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  side_t            side_in,
  input  logic [1:0][32:0] sine,
  output logic             out_valid,
  output side_t            side,
  output logic [1:0][31:0] quo
);

  logic [QuoBits-1:0] vld;
  logic [30:0] rem [QuoBits][2];
  logic [31:0] low [QuoBits][2];
  logic [31:0] q [QuoBits][2];
  side_t side_s [QuoBits];

  logic [30:0] rem_in [QuoBits][2];
  logic [31:0] low_in [QuoBits][2];
  logic [31:0] q_in [QuoBits][2];
  logic [31:0] part [QuoBits][2];
  logic [30:0] den [QuoBits];
  logic [30:0] rem_next [QuoBits][2];
  logic [31:0] q_next [QuoBits][2];

  // one quotient bit per stage and lane
  always_comb begin
    den[0] = {side_in.root, 2'd0};
    for (int i = 1; i < QuoBits; i++) begin
      den[i] = {side_s[i-1].root, 2'd0};
    end
    for (int l = 0; l < 2; l++) begin
      rem_in[0][l] = sine[l][32:2];
      low_in[0][l] = {sine[l][1:0], 30'd0};
      q_in[0][l]   = '0;
      for (int i = 1; i < QuoBits; i++) begin
        rem_in[i][l] = rem[i-1][l];
        low_in[i][l] = low[i-1][l];
        q_in[i][l]   = q[i-1][l];
      end
      for (int i = 0; i < QuoBits; i++) begin
        part[i][l] = {rem_in[i][l], low_in[i][l][31]};
        if (part[i][l] >= {1'b0, den[i]}) begin
          rem_next[i][l] = 31'(part[i][l] - {1'b0, den[i]});
          q_next[i][l]   = {q_in[i][l][30:0], 1'b1};
        end else begin
          rem_next[i][l] = part[i][l][30:0];
          q_next[i][l]   = {q_in[i][l][30:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QuoBits-2:0], in_valid};
    end
    if (en) begin
      for (int i = 0; i < QuoBits; i++) begin
        for (int l = 0; l < 2; l++) begin
          rem[i][l] <= rem_next[i][l];
          low[i][l] <= low_in[i][l] << 1;
          q[i][l]   <= q_next[i][l];
        end
      end
      side_s[0] <= side_in;
      for (int i = 1; i < QuoBits; i++) begin
        side_s[i] <= side_s[i-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      quo[l] = q[QuoBits-1][l];
    end
  end

  assign out_valid = vld[QuoBits-1];
  assign side = side_s[QuoBits-1];

endmodule

// ===== rtl/qslp_mix.sv =====
// weighted sum of the two quaternions, rounding, saturation and zeroing of skipped beats
// depends on qslp_pkg
module qslp_mix import qslp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  side_t            side,
  input  logic [1:0][31:0] quo,
  output logic             out_valid,
  output result_t          result
);

  logic [2:0] vld;
  logic [31:0] r0, r1;
  logic signed [49:0] pa [4];
  logic signed [49:0] pb [4];
  logic skip1, skip2;
  logic signed [51:0] acc [4];
  logic signed [21:0] v [4];
  logic signed [15:0] sat [4];
  result_t res;

  // weights: sine ratios or the linear fallback
  assign r0 = side.fall ? {1'b0, 16'd32768 - side.t, 15'd0} : quo[0];
  assign r1 = side.fall ? {1'b0, side.t, 15'd0} : quo[1];

  // round half up to Q.14 and clamp; skipped beats give zero
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      acc[i] = 52'(pa[i]) + 52'(pb[i]) + 52'sd536870912;
      if (v[i] > 22'sd32767) begin
        sat[i] = 16'sh7FFF;
      end else if (v[i] < -22'sd32768) begin
        sat[i] = 16'sh8000;
      end else begin
        sat[i] = v[i][15:0];
      end
      if (skip2) begin
        sat[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        pa[i] <= $signed(side.a[i]) * $signed({1'b0, r1});
        pb[i] <= $signed({side.b[i][15], side.b[i]}) * $signed({1'b0, r0});
        v[i]  <= 22'(acc[i] >>> 30);
      end
      skip1 <= side.skip;
      skip2 <= skip1;
      res.out_w   <= sat[0];
      res.out_x   <= sat[1];
      res.out_y   <= sat[2];
      res.out_z   <= sat[3];
      res.skipped <= skip2;
    end
  end

  assign out_valid = vld[2];
  assign result = res;

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for quaternion_slerp: directed table then random beats,
// each result checked against a table entry or a fixed-point slerp predictor kept here
// depends on qslp_pkg and the quaternion_slerp rtl
module testbench;
  import qslp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomBeats = 500;
  localparam int QuietBeats  = 100;
  localparam int StuckLimit  = 3000;
  localparam int Drain       = 200;
  localparam longint OneQ28  = longint'(1) << 28;

  logic     clk;
  logic     rst;
  logic     operand_valid;
  logic     operand_stall;
  operand_t operand;
  logic     result_valid;
  logic     result_stall;
  result_t  result;

  result_t  pending_results[$];
  int       error_count;
  int       stuck_cycles;
  bit       quiet;

  quaternion_slerp uut (
    .clk          (clk),
    .rst          (rst),
    .operand_valid(operand_valid),
    .operand_stall(operand_stall),
    .operand      (operand),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor integer square root
  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned root;
    longint unsigned bits;
    root = 0;
    bits = 64'd1 << 62;
    while (bits > v) bits = bits >> 2;
    while (bits != 0) begin
      if (v >= root + bits) begin
        v = v - (root + bits);
        root = (root >> 1) + bits;
      end else begin
        root = root >> 1;
      end
      bits = bits >> 2;
    end
    return root;
  endfunction

  // vectoring cordic, angle of (x, y) in Q.30
  function automatic longint vector_angle(longint x, longint y);
    longint z;
    longint dx;
    longint dy;
    z = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(AtanQ30[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(AtanQ30[i]);
      end
    end
    return z;
  endfunction

  // rotation cordic, sine of a Q.30 angle clamped at zero
  function automatic longint rotate_sine(longint z);
    longint x;
    longint y;
    longint dx;
    longint dy;
    x = longint'(CordicGain);
    y = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(AtanQ30[i]);
      end else begin
        x += dx; y -= dy; z += longint'(AtanQ30[i]);
      end
    end
    return (y < 0) ? 0 : y;
  endfunction

  // Q.44 sum rounded half up to Q.14 and saturated
  function automatic logic signed [15:0] round_sat(longint acc);
    longint v;
    v = (acc + (longint'(1) << 29)) >>> 30;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic result_t slerp_of(operand_t op);
    longint b[4];
    longint a[4];
    longint t;
    longint dot;
    longint s;
    longint theta;
    longint w0;
    longint w1;
    longint turn1;
    longint unsigned den;
    result_t r;
    b[0] = longint'($signed(op.before_w)); b[1] = longint'($signed(op.before_x));
    b[2] = longint'($signed(op.before_y)); b[3] = longint'($signed(op.before_z));
    a[0] = longint'($signed(op.after_w));  a[1] = longint'($signed(op.after_x));
    a[2] = longint'($signed(op.after_y));  a[3] = longint'($signed(op.after_z));
    t = longint'(op.blend);
    if (t > 32768) t = 32768;
    dot = a[0] * b[0] + a[1] * b[1] + a[2] * b[2] + a[3] * b[3];
    // take the short way round
    if (dot < 0) begin
      for (int i = 0; i < 4; i++) a[i] = -a[i];
      dot = -dot;
    end
    r = '0;
    if (dot * 100 < OneQ28) begin
      r.skipped = 1'b1;
      return r;
    end
    s = 0;
    theta = 0;
    if (dot < OneQ28) begin
      s = longint'(int_root((64'd1 << 56) - longint'(unsigned'(dot * dot))));
      theta = vector_angle(dot * 4, s * 4);
      if (theta < 0) theta = 0;
    end
    if (s * 100000 > OneQ28) begin
      turn1 = (theta * t) >>> 15;
      den = s * 4;
      w0 = longint'((longint'(unsigned'(rotate_sine(theta - turn1))) << 30) / den);
      w1 = longint'((longint'(unsigned'(rotate_sine(turn1))) << 30) / den);
    end else begin
      // nearly parallel: plain linear blend
      w0 = (32768 - t) << 15;
      w1 = t << 15;
    end
    r.out_w = round_sat(a[0] * w1 + b[0] * w0);
    r.out_x = round_sat(a[1] * w1 + b[1] * w0);
    r.out_y = round_sat(a[2] * w1 + b[2] * w0);
    r.out_z = round_sat(a[3] * w1 + b[3] * w0);
    r.skipped = 1'b0;
    return r;
  endfunction

  // directed table
  typedef struct {
    operand_t op;
    bit       known;
    result_t  res;
  } table_row_t;

  function automatic operand_t quat_pair(int bw, int bx, int by, int bz,
                                         int aw, int ax, int ay, int az, int t);
    operand_t o;
    o.before_w = bw[15:0]; o.before_x = bx[15:0]; o.before_y = by[15:0];
    o.before_z = bz[15:0]; o.after_w = aw[15:0]; o.after_x = ax[15:0];
    o.after_y = ay[15:0]; o.after_z = az[15:0]; o.blend = t[15:0];
    return o;
  endfunction

  function automatic result_t quat_out(int w, int x, int y, int z, bit skip);
    result_t r;
    r.out_w = w[15:0]; r.out_x = x[15:0]; r.out_y = y[15:0]; r.out_z = z[15:0];
    r.skipped = skip;
    return r;
  endfunction

  function automatic int clip16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int rand_part(bit wide);
    if (wide) return int'($signed(16'($urandom)));
    return int'($urandom_range(32768)) - 16384;
  endfunction

  function automatic operand_t random_pair();
    int bq[4];
    int aq[4];
    int kind;
    int spread;
    int t;
    kind = $urandom_range(99);
    spread = 1 << $urandom_range(14);
    for (int i = 0; i < 4; i++) begin
      bq[i] = rand_part(kind < 10);
      if (kind < 45) aq[i] = clip16(bq[i] + int'($urandom_range(2 * spread)) - spread);
      else if (kind < 55) aq[i] = -bq[i];
      else aq[i] = rand_part(kind < 15);
    end
    if ($urandom_range(9) == 0) t = $urandom_range(65535);
    else if ($urandom_range(9) == 0) t = ($urandom_range(1)) ? 32768 : 0;
    else t = $urandom_range(32768);
    return quat_pair(bq[0], bq[1], bq[2], bq[3], aq[0], aq[1], aq[2], aq[3], t);
  endfunction

  // send one operand beat, waiting out random gaps and stalls
  task automatic send_beat(input operand_t op, input result_t res);
    int gap;
    if (!quiet && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 16);
      operand_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operand <= op;
    operand_valid <= 1'b1;
    do @(posedge clk); while (operand_stall);
    pending_results.push_back(res);
  endtask

  // receiver stall bursts
  initial begin
    result_stall <= 1'b0;
    @(negedge rst);
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!quiet) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  task automatic report(string field, int want, int got);
    $display("%0t mismatch %s: expected %0d actual %0d", $realtime, field, want, got);
    error_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result beat: expected none actual %h", $realtime, result);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result.out_w !== want.out_w) report("out_w", want.out_w, result.out_w);
        if (result.out_x !== want.out_x) report("out_x", want.out_x, result.out_x);
        if (result.out_y !== want.out_y) report("out_y", want.out_y, result.out_y);
        if (result.out_z !== want.out_z) report("out_z", want.out_z, result.out_z);
        if (result.skipped !== want.skipped)
          report("skipped", want.skipped, result.skipped);
      end
    end
  end

  // watchdog on beats moving
  always @(posedge clk) begin
    if (rst || (operand_valid && !operand_stall) || (result_valid && !result_stall))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= StuckLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    table_row_t rows[$];
    operand_t   op;
    rst <= 1'b1;
    operand_valid <= 1'b0;
    operand <= '0;
    quiet = 1'b0;
    error_count = 0;
    stuck_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // identity blends: dot is exactly one, so the linear fallback is exact
    rows.push_back('{quat_pair(16384, 0, 0, 0, 16384, 0, 0, 0, 0), 1,
                     quat_out(16384, 0, 0, 0, 0)});
    rows.push_back('{quat_pair(16384, 0, 0, 0, 16384, 0, 0, 0, 32768), 1,
                     quat_out(16384, 0, 0, 0, 0)});
    rows.push_back('{quat_pair(0, 16384, 0, 0, 0, 16384, 0, 0, 65535), 1,
                     quat_out(0, 16384, 0, 0, 0)});
    // opposite signs: second quaternion flipped
    rows.push_back('{quat_pair(0, 0, 16384, 0, 0, 0, -16384, 0, 16384), 1,
                     quat_out(0, 0, 16384, 0, 0)});
    // orthogonal pair: dot below threshold
    rows.push_back('{quat_pair(16384, 0, 0, 0, 0, 0, 0, 16384, 12345), 1,
                     quat_out(0, 0, 0, 0, 1)});
    rows.push_back('{quat_pair(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, quat_out(0, 0, 0, 0, 1)});
    // quarter and general angles, dot just around the threshold
    rows.push_back('{quat_pair(16384, 0, 0, 0, 11585, 11585, 0, 0, 16384), 0, '0});
    rows.push_back('{quat_pair(16384, 0, 0, 0, 164, 16383, 0, 0, 8192), 0, '0});
    rows.push_back('{quat_pair(16384, 0, 0, 0, 163, 16383, 0, 0, 8192), 0, '0});
    rows.push_back('{quat_pair(8192, 8192, 8192, 8192, -8192, 8192, 8192, 8192, 24576), 0, '0});
    rows.push_back('{quat_pair(16384, 0, 0, 0, 16383, 180, 0, 0, 1), 0, '0});
    // out-of-range components, saturating outputs
    rows.push_back('{quat_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                               16384), 0, '0});
    rows.push_back('{quat_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                               -32768, 65535), 0, '0});
    rows.push_back('{quat_pair(-32768, 32767, -32768, 32767, 32767, -32768, 100, -5,
                               32769), 0, '0});
    rows.push_back('{quat_pair(16384, -16384, 16384, -16384, 16384, 16384, -16384, 16384,
                               32767), 0, '0});

    foreach (rows[i])
      send_beat(rows[i].op, rows[i].known ? rows[i].res : slerp_of(rows[i].op));

    for (int n = 0; n < RandomBeats; n++) begin
      // once, let the pipe drain fully before going on
      if (n == RandomBeats / 3) begin
        operand_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);
      end
      if (n == RandomBeats - QuietBeats) quiet = 1'b1;
      op = random_pair();
      send_beat(op, slerp_of(op));
    end
    operand_valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (Drain) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/qslp_pkg.sv
rtl/qslp_front.sv
rtl/qslp_isqrt.sv
rtl/qslp_vec.sv
rtl/qslp_sin.sv
rtl/qslp_div.sv
rtl/qslp_mix.sv
rtl/quaternion_slerp.sv
tb/testbench.sv
